// ===== rtl/wse_pkg.sv =====
`timescale 1ns / 1ps

package wse_pkg;

   // Field widths of the channels
   localparam int SAMPLE_W   = 16;
   localparam int TIME_W     = 32;
   localparam int INTERVAL_W = 10;
   localparam int SLOPE_W    = 27;
   localparam int COUNT_W    = 4;

   // Magnitude bits of the slope and the divider step count
   localparam int Q_W        = SLOPE_W - 1;
   localparam int DIV_CNT_W  = $clog2(Q_W);

   // 1000 ms/s times 16 for the 1/16 mm/s output step
   localparam int SCALE_Q4   = 16000;
   localparam int SCALE_W    = 14;

   localparam int WINDOW_DEFAULT = 10;

   localparam logic [INTERVAL_W-1:0] INTERVAL_RESET = INTERVAL_W'(20);

   localparam logic [SLOPE_W-1:0] SLOPE_MAX = {1'b0, {Q_W{1'b1}}};
   localparam logic [SLOPE_W-1:0] SLOPE_MIN = {1'b1, {Q_W{1'b0}}};

   // Register file: one register, selected by paddr[2]
   localparam int CSR_ADDR_W = 3;
   localparam int CSR_DATA_W = 32;
   localparam logic CSR_INTERVAL_IDX = 1'b0;

   typedef enum logic {
      OP_SAMPLE = 1'b0,
      OP_CLEAR  = 1'b1
   } op_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_SETUP,
      ST_WALK,
      ST_PROD_A,
      ST_PROD_B,
      ST_NUMER,
      ST_PROD_C,
      ST_PROD_D,
      ST_DENOM,
      ST_CHECK,
      ST_DIVIDE,
      ST_DONE
   } state_type;

endpackage

// ===== rtl/wse_ram.sv =====
`timescale 1ns / 1ps

module wse_ram #(
   parameter int WIDTH = wse_pkg::SAMPLE_W,
   parameter int DEPTH = wse_pkg::WINDOW_DEFAULT
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic                     re,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      if (re) begin
         rdata_ff <= mem_ff[raddr];
      end
   end

   assign rdata = rdata_ff;

endmodule

// ===== rtl/window_slope_estimator_unit.sv =====
`timescale 1ns / 1ps

// Sliding-window slope estimator.
// req channel: one transfer per item. req_tuser is the op (0 = offer a sample,
// 1 = clear the window); req_tdata carries the sample in mm and the time in ms.
// A sample is stored when the wrapped gap to the last stored time reaches
// interval_ms (or 1 ms if it is 0). rsp channel: one transfer per item with
// the least-squares slope of the stored samples in 1/16 mm/s, the stored count
// and the accepted flag. csr port: interval_ms at byte address 0, written with
// an APB write, read back on prdata; write it only while no item is in flight.
// Work per item: after the input transfer the block sets up, walks the sample
// memory from the oldest stored sample (one read a cycle), forms the products,
// the numerator and the denominator and runs the 26-step restoring divider;
// with fewer than two samples stored it goes straight to the result. The next
// item is taken once the result has gone into the output register.
// Reset empties the window, zeroes the last store time and sets interval_ms to 20.
// The result waits in an output register; while the receiver stalls, the block
// still takes and works the next item and then holds until the register frees.
module window_slope_estimator_unit #(
   parameter int WINDOW = wse_pkg::WINDOW_DEFAULT
) (
   input  logic                            clock,
   input  logic                            reset,
   // req_tdata: [15:0] sample_mm, [47:16] time_ms
   input  logic                            req_tvalid,
   output logic                            req_tready,
   input  logic [47:0]                     req_tdata,
   // req_tuser: [0] op
   input  logic                            req_tuser,
   // rsp_tdata: [26:0] slope_q4, [30:27] stored_count, [31] accepted
   output logic                            rsp_tvalid,
   input  logic                            rsp_tready,
   output logic [31:0]                     rsp_tdata,
   input  logic                            csr_psel,
   input  logic                            csr_penable,
   input  logic                            csr_pwrite,
   input  logic [wse_pkg::CSR_ADDR_W-1:0]  csr_paddr,
   input  logic [wse_pkg::CSR_DATA_W-1:0]  csr_pwdata,
   output logic [wse_pkg::CSR_DATA_W-1:0]  csr_prdata,
   output logic                            csr_pready
);

   localparam int SAMPLE_W = wse_pkg::SAMPLE_W;
   localparam int TIME_W   = wse_pkg::TIME_W;
   localparam int IV_W     = wse_pkg::INTERVAL_W;
   localparam int Q_W      = wse_pkg::Q_W;
   localparam int SLOPE_W  = wse_pkg::SLOPE_W;

   localparam int IDX_W   = $clog2(WINDOW);
   localparam int CNT_W   = $clog2(WINDOW + 1);
   localparam int ST_MAX  = WINDOW * (WINDOW - 1) / 2;
   localparam int ST_W    = $clog2(ST_MAX + 1);
   localparam int STT_MAX = (WINDOW - 1) * WINDOW * (2 * WINDOW - 1) / 6;
   localparam int STT_W   = $clog2(STT_MAX + 1);
   localparam int SY_W    = SAMPLE_W + CNT_W;
   localparam int STY_W   = SAMPLE_W + ST_W;
   // n*Sty and St*Sy are the widest products; n*Stt and St*St fit below them
   localparam int P_W     = (CNT_W + STY_W > ST_W + SY_W) ? CNT_W + STY_W : ST_W + SY_W;
   localparam int D_W     = P_W + 1;
   localparam int NUM_W   = D_W + wse_pkg::SCALE_W;
   localparam int DEN_W   = P_W + IV_W;
   localparam int CMP_W   = (NUM_W > DEN_W + Q_W) ? NUM_W : DEN_W + Q_W;
   localparam int DC_W    = wse_pkg::DIV_CNT_W;

   localparam logic signed [NUM_W-1:0] SCALE_S = NUM_W'(wse_pkg::SCALE_Q4);

   wse_pkg::state_type state_ff, state_in;

   logic [IV_W-1:0]     interval_ff, interval_in;
   logic [CNT_W-1:0]    fill_ff, fill_in;
   logic [IDX_W-1:0]    wslot_ff, wslot_in;
   logic [TIME_W-1:0]   last_ff, last_in;
   logic [IDX_W-1:0]    ptr_ff, ptr_in;
   logic [CNT_W-1:0]    walk_cnt_ff, walk_cnt_in;
   logic [ST_W-1:0]     st_ff, st_in;
   logic [SY_W-1:0]     sy_ff, sy_in;
   logic [STY_W-1:0]    sty_ff, sty_in;
   logic [STT_W-1:0]    stt_ff, stt_in;
   logic [P_W-1:0]      pa_ff, pa_in;
   logic [P_W-1:0]      pb_ff, pb_in;
   logic signed [NUM_W-1:0] num_ff, num_in;
   logic [NUM_W-1:0]    mag_ff, mag_in;
   logic                neg_ff, neg_in;
   logic [DEN_W-1:0]    den_ff, den_in;
   logic                sat_ff, sat_in;
   logic [DEN_W-1:0]    rem_ff, rem_in;
   logic [Q_W-1:0]      quo_ff, quo_in;
   logic [DC_W-1:0]     div_cnt_ff, div_cnt_in;
   logic                zero_ff, zero_in;
   logic                acc_ff, acc_in;
   logic                rsp_valid_ff, rsp_valid_in;
   logic [31:0]         rsp_data_ff, rsp_data_in;

   logic                ram_we;
   logic                ram_re;
   logic [IDX_W-1:0]    ram_raddr;
   logic [SAMPLE_W-1:0] ram_rdata;

   logic [SAMPLE_W-1:0] req_sample;
   logic [TIME_W-1:0]   req_time;
   logic [IV_W-1:0]     eff_interval;
   logic [TIME_W-1:0]   gap;
   logic [CNT_W:0]      start_sum;
   logic [IDX_W-1:0]    t_idx;
   logic signed [D_W-1:0]   diff_s;
   logic signed [NUM_W-1:0] diff_ext;
   logic [CMP_W-1:0]    mag_ext;
   logic [DEN_W:0]      rem_sh;
   logic                rem_ge;
   logic [SLOPE_W-1:0]  slope;
   logic                csr_wr;

   assign req_sample   = req_tdata[SAMPLE_W-1:0];
   assign req_time     = req_tdata[SAMPLE_W +: TIME_W];
   assign eff_interval = (interval_ff == '0) ? IV_W'(1) : interval_ff;
   assign gap          = req_time - last_ff;
   assign start_sum    = (CNT_W+1)'(wslot_ff)
                       + (((CNT_W+1)'(wslot_ff) < (CNT_W+1)'(fill_ff))
                          ? (CNT_W+1)'(WINDOW) : '0)
                       - (CNT_W+1)'(fill_ff);
   assign t_idx        = IDX_W'(walk_cnt_ff - 1'b1);
   assign diff_s       = $signed({1'b0, pa_ff}) - $signed({1'b0, pb_ff});
   assign diff_ext     = NUM_W'(diff_s);
   assign mag_ext      = CMP_W'(mag_ff);
   assign rem_sh       = {rem_ff, quo_ff[Q_W-1]};
   assign rem_ge       = rem_sh >= {1'b0, den_ff};

   always_comb begin
      logic [SLOPE_W-1:0] q_ext;
      q_ext = {1'b0, quo_ff};
      if (zero_ff) begin
         slope = '0;
      end else if (sat_ff) begin
         slope = neg_ff ? wse_pkg::SLOPE_MIN : wse_pkg::SLOPE_MAX;
      end else begin
         slope = neg_ff ? SLOPE_W'(-q_ext) : q_ext;
      end
   end

   // Configuration port
   assign csr_pready = 1'b1;
   assign csr_wr     = csr_psel & csr_penable & csr_pwrite & csr_pready
                     & (csr_paddr[wse_pkg::CSR_ADDR_W-1] == wse_pkg::CSR_INTERVAL_IDX);
   assign csr_prdata = (csr_paddr[wse_pkg::CSR_ADDR_W-1] == wse_pkg::CSR_INTERVAL_IDX)
                     ? wse_pkg::CSR_DATA_W'(interval_ff) : '0;
   assign interval_in = csr_wr ? csr_pwdata[IV_W-1:0] : interval_ff;

   wse_ram #(
      .WIDTH (SAMPLE_W),
      .DEPTH (WINDOW)
   ) u_ram (
      .clock (clock),
      .we    (ram_we),
      .waddr (wslot_ff),
      .wdata (req_sample),
      .re    (ram_re),
      .raddr (ram_raddr),
      .rdata (ram_rdata)
   );

   always_comb begin
      state_in     = state_ff;
      fill_in      = fill_ff;
      wslot_in     = wslot_ff;
      last_in      = last_ff;
      ptr_in       = ptr_ff;
      walk_cnt_in  = walk_cnt_ff;
      st_in        = st_ff;
      sy_in        = sy_ff;
      sty_in       = sty_ff;
      stt_in       = stt_ff;
      pa_in        = pa_ff;
      pb_in        = pb_ff;
      num_in       = num_ff;
      mag_in       = mag_ff;
      neg_in       = neg_ff;
      den_in       = den_ff;
      sat_in       = sat_ff;
      rem_in       = rem_ff;
      quo_in       = quo_ff;
      div_cnt_in   = div_cnt_ff;
      zero_in      = zero_ff;
      acc_in       = acc_ff;
      rsp_data_in  = rsp_data_ff;
      rsp_valid_in = rsp_valid_ff & ~rsp_tready;
      ram_we       = 1'b0;
      ram_re       = 1'b0;
      ram_raddr    = ptr_ff;
      req_tready   = 1'b0;

      case (state_ff)
         wse_pkg::ST_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               acc_in   = 1'b0;
               state_in = wse_pkg::ST_SETUP;
               if (wse_pkg::op_type'(req_tuser) == wse_pkg::OP_CLEAR) begin
                  fill_in  = '0;
                  wslot_in = '0;
                  last_in  = '0;
               end else if (gap >= TIME_W'(eff_interval)) begin
                  ram_we   = 1'b1;
                  wslot_in = (wslot_ff == IDX_W'(WINDOW - 1)) ? '0 : wslot_ff + 1'b1;
                  if (fill_ff != CNT_W'(WINDOW)) begin
                     fill_in = fill_ff + 1'b1;
                  end
                  last_in  = req_time;
                  acc_in   = 1'b1;
               end
            end
         end
         wse_pkg::ST_SETUP: begin
            // start at the oldest stored sample
            ptr_in      = IDX_W'(start_sum);
            walk_cnt_in = '0;
            st_in       = '0;
            sy_in       = '0;
            sty_in      = '0;
            stt_in      = '0;
            zero_in     = fill_ff < CNT_W'(2);
            state_in    = (fill_ff < CNT_W'(2)) ? wse_pkg::ST_DONE : wse_pkg::ST_WALK;
         end
         wse_pkg::ST_WALK: begin
            if (walk_cnt_ff < fill_ff) begin
               ram_re = 1'b1;
               ptr_in = (ptr_ff == IDX_W'(WINDOW - 1)) ? '0 : ptr_ff + 1'b1;
            end
            // data read in the previous cycle belongs to t = walk_cnt - 1
            if (walk_cnt_ff != '0) begin
               st_in  = st_ff + ST_W'(t_idx);
               sy_in  = sy_ff + SY_W'(ram_rdata);
               sty_in = sty_ff + STY_W'(t_idx) * STY_W'(ram_rdata);
               stt_in = stt_ff + STT_W'(t_idx) * STT_W'(t_idx);
            end
            if (walk_cnt_ff == fill_ff) begin
               state_in = wse_pkg::ST_PROD_A;
            end else begin
               walk_cnt_in = walk_cnt_ff + 1'b1;
            end
         end
         wse_pkg::ST_PROD_A: begin
            pa_in    = P_W'(fill_ff) * P_W'(sty_ff);
            state_in = wse_pkg::ST_PROD_B;
         end
         wse_pkg::ST_PROD_B: begin
            pb_in    = P_W'(st_ff) * P_W'(sy_ff);
            state_in = wse_pkg::ST_NUMER;
         end
         wse_pkg::ST_NUMER: begin
            num_in   = diff_ext * SCALE_S;
            state_in = wse_pkg::ST_PROD_C;
         end
         wse_pkg::ST_PROD_C: begin
            pa_in    = P_W'(fill_ff) * P_W'(stt_ff);
            neg_in   = num_ff[NUM_W-1];
            mag_in   = num_ff[NUM_W-1] ? $unsigned(-num_ff) : $unsigned(num_ff);
            state_in = wse_pkg::ST_PROD_D;
         end
         wse_pkg::ST_PROD_D: begin
            pb_in    = P_W'(st_ff) * P_W'(st_ff);
            state_in = wse_pkg::ST_DENOM;
         end
         wse_pkg::ST_DENOM: begin
            den_in   = DEN_W'(pa_ff - pb_ff) * DEN_W'(eff_interval);
            state_in = wse_pkg::ST_CHECK;
         end
         wse_pkg::ST_CHECK: begin
            // quotient of 2^26 or more saturates; otherwise the top part is below den
            sat_in     = mag_ext >= (CMP_W'(den_ff) << Q_W);
            rem_in     = mag_ext[Q_W +: DEN_W];
            quo_in     = mag_ff[Q_W-1:0];
            div_cnt_in = DC_W'(Q_W - 1);
            state_in   = wse_pkg::ST_DIVIDE;
         end
         wse_pkg::ST_DIVIDE: begin
            rem_in = rem_ge ? DEN_W'(rem_sh - {1'b0, den_ff}) : DEN_W'(rem_sh);
            quo_in = {quo_ff[Q_W-2:0], rem_ge};
            if (div_cnt_ff == '0) begin
               state_in = wse_pkg::ST_DONE;
            end else begin
               div_cnt_in = div_cnt_ff - 1'b1;
            end
         end
         wse_pkg::ST_DONE: begin
            // hold until the output register frees
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_data_in  = {acc_ff, wse_pkg::COUNT_W'(fill_ff), slope};
               rsp_valid_in = 1'b1;
               state_in     = wse_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = wse_pkg::ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= wse_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         interval_ff  <= wse_pkg::INTERVAL_RESET;
         fill_ff      <= '0;
         wslot_ff     <= '0;
         last_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         interval_ff  <= interval_in;
         fill_ff      <= fill_in;
         wslot_ff     <= wslot_in;
         last_ff      <= last_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      ptr_ff      <= ptr_in;
      walk_cnt_ff <= walk_cnt_in;
      st_ff       <= st_in;
      sy_ff       <= sy_in;
      sty_ff      <= sty_in;
      stt_ff      <= stt_in;
      pa_ff       <= pa_in;
      pb_ff       <= pb_in;
      num_ff      <= num_in;
      mag_ff      <= mag_in;
      neg_ff      <= neg_in;
      den_ff      <= den_in;
      sat_ff      <= sat_in;
      rem_ff      <= rem_in;
      quo_ff      <= quo_in;
      div_cnt_ff  <= div_cnt_in;
      zero_ff     <= zero_in;
      acc_ff      <= acc_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   // An input transfer always starts work; the block is never idle the cycle after
   a_busy_after_transfer: assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready) |=> (state_ff != wse_pkg::ST_IDLE))
      else $error("block idle right after an input transfer");

   // The window never holds more than WINDOW samples
   a_fill_bound: assert property (@(posedge clock) disable iff (reset)
      (fill_ff <= CNT_W'(WINDOW)))
      else $error("fill count beyond window depth");

   // Restoring divider keeps its remainder below the divisor
   a_div_rem: assert property (@(posedge clock) disable iff (reset)
      (state_ff == wse_pkg::ST_DIVIDE && !sat_ff) |-> (rem_ff < den_ff))
      else $error("divider remainder not below divisor");

   // A computed slope needs at least two samples behind it
   a_slope_fill: assert property (@(posedge clock) disable iff (reset)
      (state_ff == wse_pkg::ST_DONE && !zero_ff) |-> (fill_ff >= CNT_W'(2)))
      else $error("slope computed with fewer than two samples");

endmodule

// ===== sim/wse_checker.sv =====
`timescale 1ns / 1ps

module wse_checker (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_tvalid,
   input  logic                                req_tready,
   // req_tdata: [15:0] sample_mm, [47:16] time_ms
   input  logic [47:0]                         req_tdata,
   // req_tuser: [0] op
   input  logic                                req_tuser,
   input  logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   // rsp_tdata: [26:0] slope_q4, [30:27] stored_count, [31] accepted
   input  logic [31:0]                         rsp_tdata,
   input  logic                                csr_psel,
   input  logic                                csr_penable,
   input  logic                                csr_pwrite,
   input  logic [wse_pkg::CSR_ADDR_W-1:0]      csr_paddr,
   input  logic [wse_pkg::CSR_DATA_W-1:0]      csr_pwdata,
   input  logic [wse_pkg::CSR_DATA_W-1:0]      csr_prdata,
   input  logic                                csr_pready,
   output int                                  error_count,
   output int                                  outstanding
);

   import wse_pkg::*;

   localparam int     WIN     = WINDOW_DEFAULT;
   localparam longint FIT_MAX = (longint'(1) <<< Q_W) - 1;
   localparam longint FIT_MIN = -(longint'(1) <<< Q_W);

   // Same bit layout as rsp_tdata, highest field first
   typedef struct packed {
      logic               accepted;
      logic [COUNT_W-1:0] count;
      logic [SLOPE_W-1:0] slope;
   } range_fit_t;

   logic [SAMPLE_W-1:0]   ring [WIN];
   int unsigned           head;
   int unsigned           fill;
   logic [TIME_W-1:0]     last_stored_ms;
   logic [INTERVAL_W-1:0] interval_ms;
   range_fit_t            expected_fits [$];

   task automatic flag_error(input string msg);
      error_count++;
      if (error_count <= 10) $display("%s", msg);
   endtask

   // Update the window with one item and fit a line through the stored samples
   function automatic range_fit_t track_range(input op_type op, input logic [15:0] mm,
                                              input logic [31:0] now);
      range_fit_t  fit;
      logic [31:0] min_gap;
      int unsigned oldest;
      longint      n, st, sy, sty, stt, y, num, den, q;
      fit = '0;
      min_gap = (interval_ms == '0) ? 32'd1 : {{(32 - INTERVAL_W){1'b0}}, interval_ms};
      if (op == OP_CLEAR) begin
         for (int k = 0; k < WIN; k++) ring[k] = '0;
         head = 0;
         fill = 0;
         last_stored_ms = '0;
      end else if (32'(now - last_stored_ms) >= min_gap) begin
         ring[head] = mm;
         head = (head + 1) % WIN;
         if (fill < WIN) fill++;
         last_stored_ms = now;
         fit.accepted = 1'b1;
      end
      q = 0;
      if (fill >= 2) begin
         n = fill;
         st = 0; sy = 0; sty = 0; stt = 0;
         oldest = (head + WIN - fill) % WIN;
         for (int k = 0; k < fill; k++) begin
            y = longint'(ring[(oldest + k) % WIN]);
            st += k;
            sy += y;
            sty += k * y;
            stt += k * k;
         end
         den = (n * stt - st * st) * longint'(min_gap);
         num = (n * sty - st * sy) * SCALE_Q4;
         if (den > 0) q = num / den;
         if (q > FIT_MAX) q = FIT_MAX;
         if (q < FIT_MIN) q = FIT_MIN;
      end
      fit.slope = q[SLOPE_W-1:0];
      fit.count = fill[COUNT_W-1:0];
      return fit;
   endfunction

   always @(posedge clock) begin : monitor
      range_fit_t seen, want;
      if (reset) begin
         for (int k = 0; k < WIN; k++) ring[k] = '0;
         head = 0;
         fill = 0;
         last_stored_ms = '0;
         interval_ms = INTERVAL_RESET;
         expected_fits.delete();
         error_count = 0;
         outstanding <= 0;
      end else begin
         if (csr_psel && csr_penable && csr_pready && csr_paddr[2] == CSR_INTERVAL_IDX) begin
            if (csr_pwrite)
               interval_ms = csr_pwdata[INTERVAL_W-1:0];
            else if (csr_prdata !== {{(CSR_DATA_W - INTERVAL_W){1'b0}}, interval_ms})
               flag_error($sformatf("interval_ms readback: expected %0d, got %0d",
                                    interval_ms, csr_prdata));
         end
         if (rsp_tvalid && rsp_tready) begin
            seen = rsp_tdata;
            if (expected_fits.size() == 0) begin
               flag_error($sformatf("unexpected result transfer 0x%08h", rsp_tdata));
            end else begin
               want = expected_fits.pop_front();
               if (seen.slope !== want.slope || seen.count !== want.count
                   || seen.accepted !== want.accepted)
                  flag_error($sformatf({"result mismatch: expected slope %0d count %0d ",
                                        "accepted %0d, got slope %0d count %0d accepted %0d"},
                                       $signed(want.slope), want.count, want.accepted,
                                       $signed(seen.slope), seen.count, seen.accepted));
            end
         end
         if (req_tvalid && req_tready)
            expected_fits.push_back(track_range(op_type'(req_tuser), req_tdata[15:0],
                                                req_tdata[47:16]));
         outstanding <= expected_fits.size();
      end
   end

endmodule

// ===== sim/tb.sv =====
`timescale 1ns / 1ps

module tb;

   import wse_pkg::*;

   localparam int CYCLE_LIMIT = 1200000;
   localparam int HOLD_CYCLES = 1500;
   localparam int PHASE_ITEMS = 195;
   localparam logic [CSR_ADDR_W-1:0] INTERVAL_ADDR = {CSR_INTERVAL_IDX, 2'b00};

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_tvalid = 1'b0;
   logic                  req_tready;
   logic [47:0]           req_tdata = '0;
   logic                  req_tuser = OP_SAMPLE;
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   logic [31:0]           rsp_tdata;
   logic                  csr_psel = 1'b0;
   logic                  csr_penable = 1'b0;
   logic                  csr_pwrite = 1'b0;
   logic [CSR_ADDR_W-1:0] csr_paddr = '0;
   logic [CSR_DATA_W-1:0] csr_pwdata = '0;
   logic [CSR_DATA_W-1:0] csr_prdata;
   logic                  csr_pready;

   int          error_count;
   int          outstanding;
   int          cycles = 0;
   bit          no_idle = 1'b0;
   bit          hold_rsp = 1'b0;
   int unsigned cur_interval = 20;
   logic [31:0] now_ms;
   logic [15:0] level_mm;

   window_slope_estimator_unit dut (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .req_tuser   (req_tuser),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   wse_checker u_checker (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .req_tuser   (req_tuser),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .error_count (error_count),
      .outstanding (outstanding)
   );

   always #10 clock = ~clock;

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > CYCLE_LIMIT) begin
         $display("tb failed");
         $finish;
      end
   end

   // Result sink: random runs and stalls, plus one long hold-off on request
   initial begin : sink
      int run_left, stall_left, r;
      run_left = 0;
      stall_left = 0;
      forever begin
         @(posedge clock);
         if (hold_rsp) begin
            rsp_tready <= 1'b0;
            repeat (HOLD_CYCLES) @(posedge clock);
            hold_rsp = 1'b0;
            rsp_tready <= 1'b1;
         end else if (no_idle || run_left > 0) begin
            rsp_tready <= 1'b1;
            if (run_left > 0) run_left--;
         end else if (stall_left > 0) begin
            rsp_tready <= 1'b0;
            stall_left--;
         end else begin
            r = $urandom_range(0, 99);
            run_left = $urandom_range(0, 12);
            stall_left = (r < 80) ? $urandom_range(1, 3) :
                         (r < 95) ? $urandom_range(4, 10) : $urandom_range(30, 80);
            rsp_tready <= 1'b1;
         end
      end
   end

   task automatic offer(input op_type op, input logic [15:0] mm, input logic [31:0] ms);
      int idle, r;
      r = $urandom_range(0, 99);
      idle = 0;
      if (!no_idle)
         idle = (r < 70) ? 0 : (r < 95) ? $urandom_range(1, 5) : $urandom_range(20, 40);
      if (idle > 0) begin
         req_tvalid <= 1'b0;
         repeat (idle) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser <= op;
      req_tdata <= {ms, mm};
      do @(posedge clock); while (!req_tready);
   endtask

   // Hold the input until every outstanding result has been taken
   task automatic drain();
      req_tvalid <= 1'b0;
      do @(posedge clock); while (outstanding != 0);
   endtask

   task automatic csr_access(input logic wr, input logic [CSR_DATA_W-1:0] data);
      csr_psel <= 1'b1;
      csr_pwrite <= wr;
      csr_paddr <= INTERVAL_ADDR;
      csr_pwdata <= data;
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b0;
      @(posedge clock);
   endtask

   task automatic program_interval(input int unsigned value);
      logic [CSR_DATA_W-1:0] upper;
      upper = $urandom_range(0, 1) ? ($urandom & ~32'h3FF) : '0;
      drain();
      csr_access(1'b1, upper | value);
      csr_access(1'b0, '0);
      cur_interval = value & 32'h3FF;
   endtask

   task automatic run_phase(input int items);
      int          r;
      int unsigned min_gap, gap;
      min_gap = (cur_interval == 0) ? 1 : cur_interval;
      // Start half the phases just below the time wrap
      if ($urandom_range(0, 1)) now_ms = 32'hFFFFF000 + $urandom_range(0, 4095);
      else now_ms = $urandom;
      level_mm = 16'($urandom);
      for (int i = 0; i < items; i++) begin
         r = $urandom_range(0, 99);
         if (r < 3) begin
            offer(OP_CLEAR, 16'($urandom), $urandom);
         end else if (r < 10) begin
            offer(OP_SAMPLE, 16'($urandom), $urandom);
         end else begin
            r = $urandom_range(0, 9);
            gap = (r < 6) ? min_gap + $urandom_range(0, min_gap / 2) :
                  (r < 8) ? $urandom_range(0, min_gap - 1) :
                  (r < 9) ? min_gap : $urandom_range(0, 100000);
            now_ms += gap;
            r = $urandom_range(0, 9);
            if (r < 7) level_mm += 16'($urandom_range(0, 400) - 200);
            else if (r < 9) level_mm = 16'($urandom);
            else level_mm = $urandom_range(0, 1) ? 16'hFFFF : 16'h0000;
            offer(OP_SAMPLE, level_mm, now_ms);
         end
      end
   endtask

   initial begin : stimulus
      int unsigned interval_plan [8];
      int unsigned value;
      interval_plan = '{137, 1, 1000, 0, 1023, 20, 5, 600};
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      csr_access(1'b0, '0);

      // Reset interval: first-sample rule, time wrap, ring wrap, clear
      offer(OP_SAMPLE, 16'd1, 32'd0);
      offer(OP_SAMPLE, 16'd2, 32'd19);
      offer(OP_SAMPLE, 16'd0, 32'd20);
      offer(OP_SAMPLE, 16'd9, 32'd30);
      offer(OP_SAMPLE, 16'hFFFF, 32'd40);
      offer(OP_SAMPLE, 16'd0, 32'd60);
      offer(OP_SAMPLE, 16'hFFFF, 32'hFFFFFFF0);
      offer(OP_SAMPLE, 16'd1234, 32'h00000010);
      now_ms = 32'h00000010;
      for (int i = 0; i < 6; i++) begin
         now_ms += 20;
         offer(OP_SAMPLE, (i % 2) ? 16'hFFFF : 16'(i * 5000), now_ms);
      end
      offer(OP_CLEAR, 16'hFFFF, 32'hFFFFFFFF);
      offer(OP_SAMPLE, 16'd7, 32'd19);
      offer(OP_SAMPLE, 16'd7, 32'd20);

      // Shortest interval: drive the slope into both saturation limits
      program_interval(1);
      offer(OP_SAMPLE, 16'd0, 32'd100);
      offer(OP_SAMPLE, 16'hFFFF, 32'd101);
      offer(OP_CLEAR, 16'h0000, 32'h00000000);
      offer(OP_SAMPLE, 16'hFFFF, 32'd1);
      offer(OP_SAMPLE, 16'd0, 32'd2);
      offer(OP_SAMPLE, 16'd0, 32'd2);

      for (int p = 0; p < 8; p++) begin
         value = (p == 7) ? $urandom_range(1, 1000) : interval_plan[p];
         program_interval(value);
         no_idle = (p == 2);
         if (p == 1) hold_rsp = 1'b1;
         run_phase(PHASE_ITEMS);
      end

      drain();
      repeat (60) @(posedge clock);
      if (error_count == 0) begin
         $display("tb passed");
      end else begin
         $display("tb failed");
      end
      $finish;
   end

endmodule
